### hdl/scd_pkg.sv
// Shared types and opcodes of the sector cache directory.
package scd_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] sector;
    logic [31:0] time_stamp;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [5:0]  entry_index;
    logic        fill_needed;
    logic        writeback_needed;
    logic [31:0] writeback_sector;
    logic        last;
  } rsp_t;

endpackage

### hdl/sector_cache_directory_lru.sv
// Sector cache directory: a read or write scans every entry through the single read port
// of the tag and stamp memory, closes the scan, updates the entry and presents the result,
// which it holds until taken, then returns to idle; a flush walks every entry through the
// same port, holds while a result is stalled and reissues the read of the entry after the
// stalled result once it drains. A no-op request is accepted and gives no result. A new
// request is accepted only in idle.
// Valid and dirty marks sit in flip-flops; tags and stamps sit in one memory.
module sector_cache_directory_lru #(
  parameter int ENTRIES = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  scd_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output scd_pkg::rsp_t out_data
);
  import scd_pkg::*;

  localparam int IW = $clog2(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_UPDATE, S_FLUSH, S_OUT
  } state_t;

  state_t          state;
  req_t            req;
  logic [63:0]     mem [ENTRIES];
  logic [63:0]     rd_data;
  logic [IW:0]     cnt;
  logic [IW-1:0]   rd_idx;
  logic            rd_pend;
  logic [IW-1:0]   rd_at;
  logic [ENTRIES-1:0] valid_marks;
  logic [ENTRIES-1:0] dirty_marks;
  logic            found;
  logic [IW-1:0]   hit_idx;
  logic [IW-1:0]   best_idx;
  logic [31:0]     best_stamp;
  logic            have_inv;
  logic [IW-1:0]   inv_idx;
  logic [IW-1:0]   victim;
  logic            mem_we;
  logic [IW-1:0]   mem_wa;
  logic [63:0]     mem_wd;
  logic [ENTRIES-1:0] later_mask;
  logic [31:0]     vic_tag;

  assign in_ready = (state == S_IDLE);
  assign rd_idx   = cnt[IW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[rd_idx];
  end

  // Victim: lowest invalid entry, else oldest stamp.
  assign victim = have_inv ? inv_idx : best_idx;

  always_comb begin
    later_mask = '0;
    for (int k = 0; k < ENTRIES; k++) later_mask[k] = (k > int'(rd_at));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      valid_marks <= '0;
      dirty_marks <= '0;
      out_valid   <= 1'b0;
      rd_pend     <= 1'b0;
      mem_we      <= 1'b0;
      cnt         <= '0;
    end else begin
      mem_we <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req      <= in_data;
            cnt      <= '0;
            rd_pend  <= 1'b0;
            found    <= 1'b0;
            have_inv <= 1'b0;
            best_idx <= '0;
            if (in_data.opcode == OP_FLUSH) begin
              state <= S_FLUSH;
            end else if (in_data.opcode == OP_NONE) begin
              state <= S_IDLE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Issue read of entry cnt; evaluate the entry read last cycle.
          rd_pend <= (cnt < (IW+1)'(ENTRIES));
          rd_at   <= rd_idx;
          if (cnt < (IW+1)'(ENTRIES)) cnt <= cnt + 1'b1;
          if (rd_pend) begin
            if (valid_marks[rd_at]) begin
              if (!found && rd_data[63:32] == req.sector) begin
                found   <= 1'b1;
                hit_idx <= rd_at;
              end
              if (rd_at == '0 || rd_data[31:0] < best_stamp) begin
                best_idx   <= rd_at;
                best_stamp <= rd_data[31:0];
              end
            end else if (!have_inv) begin
              have_inv <= 1'b1;
              inv_idx  <= rd_at;
            end
          end
          if (!rd_pend && cnt == (IW+1)'(ENTRIES)) state <= S_UPDATE;
        end
        S_UPDATE: begin
          mem_we                   <= 1'b1;
          out_valid                <= 1'b1;
          out_data.last            <= 1'b1;
          state                    <= S_OUT;
          if (found) begin
            mem_wa <= hit_idx;
            mem_wd <= {req.sector, req.time_stamp};
            if (req.opcode == OP_WRITE) dirty_marks[hit_idx] <= 1'b1;
            out_data.hit              <= 1'b1;
            out_data.entry_index      <= 6'(hit_idx);
            out_data.fill_needed      <= 1'b0;
            out_data.writeback_needed <= 1'b0;
            out_data.writeback_sector <= '0;
          end else begin
            mem_wa <= victim;
            mem_wd <= {req.sector, req.time_stamp};
            valid_marks[victim]       <= 1'b1;
            dirty_marks[victim]       <= (req.opcode == OP_WRITE);
            out_data.hit              <= 1'b0;
            out_data.entry_index      <= 6'(victim);
            out_data.fill_needed      <= 1'b1;
            out_data.writeback_needed <= valid_marks[victim] & dirty_marks[victim];
            out_data.writeback_sector <= (valid_marks[victim] & dirty_marks[victim])
                                         ? vic_tag : '0;
          end
        end
        S_FLUSH: begin
          // Walk entries; read at cnt, emit for rd_at when valid.
          if (!out_valid || out_ready) begin
            out_valid <= 1'b0;
            rd_pend   <= (cnt < (IW+1)'(ENTRIES));
            rd_at     <= rd_idx;
            if (cnt < (IW+1)'(ENTRIES)) cnt <= cnt + 1'b1;
            if (rd_pend && valid_marks[rd_at]) begin
              out_valid                 <= 1'b1;
              out_data.hit              <= 1'b0;
              out_data.entry_index      <= 6'(rd_at);
              out_data.fill_needed      <= 1'b0;
              out_data.writeback_needed <= 1'b1;
              out_data.writeback_sector <= rd_data[63:32];
              out_data.last             <= ~|(valid_marks & later_mask);
            end
            if (!rd_pend && cnt == (IW+1)'(ENTRIES)) begin
              dirty_marks <= '0;
              state       <= S_IDLE;
            end
          end else begin
            // Rewind to the pending entry so it is re-read once the result drains.
            rd_pend <= 1'b0;
            if (rd_pend) cnt <= {1'b0, rd_at};
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Victim tag is captured during the scan.
  always_ff @(posedge clk) begin
    if (state == S_SCAN && rd_pend && valid_marks[rd_at] &&
        (rd_at == '0 || rd_data[31:0] < best_stamp))
      vic_tag <= rd_data[63:32];
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input ready while a result is pending");
  a_fill_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.hit && out_data.fill_needed))
    else $error("hit and fill at once");
  a_wb_sector: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.writeback_needed) |-> out_data.writeback_sector == '0)
    else $error("writeback sector without writeback");
`endif

endmodule
